FILE: src/cds_pkg.sv
// Shared types, constants and calendar helpers for the date stepper.
package cds_pkg;

    // Operation codes carried in the input tuser
    typedef enum logic [2:0] {
        OP_SET       = 3'd0,
        OP_ADD_DAYS  = 3'd1,
        OP_SUB_DAYS  = 3'd2,
        OP_ADD_MONTH = 3'd3,
        OP_SUB_MONTH = 3'd4,
        OP_ADD_YEARS = 3'd5,
        OP_SUB_YEARS = 3'd6,
        OP_COMPARE   = 3'd7
    } t_op;

    // Work class decided by the front part
    typedef enum logic [2:0] {
        K_SET   = 3'd0,
        K_DAY   = 3'd1,
        K_MONTH = 3'd2,
        K_YEAR  = 3'd3,
        K_CMP   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  down;
    } t_cls;

    // Result item, last member in the lowest bits
    typedef struct packed {
        logic        matches_res;
        logic        leap;
        logic [4:0]  month_length;
        logic [11:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
    } t_result;

    localparam int unsigned DATE_W      = 21;
    localparam int unsigned RESULT_W    = $bits(t_result);
    localparam int unsigned OUT_DATA_W  = ((RESULT_W + 7) / 8) * 8;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [11:0] YEAR_MIN  = 12'd1600;
    localparam logic [11:0] YEAR_MAX  = 12'd2100;
    localparam logic [3:0]  MONTH_MAX = 4'd12;

    // Leap rule over the kept range: every fourth year except 1700, 1800, 1900, 2100
    function automatic logic cds_is_leap(input logic [11:0] year);
        logic century;
        century = (year == 12'd1700) || (year == 12'd1800) ||
                  (year == 12'd1900) || (year == 12'd2100);
        return (year[1:0] == 2'b00) && !century;
    endfunction

    // Days in a month; codes outside 1..12 read 31
    function automatic logic [4:0] cds_month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: src/calendar_date_stepper_core.sv
// Top level of the calendar date stepper: front decode, queue, stepping back part.
//
//  Channel   Dir  Signals                         Contents
//  s_axis    in   tvalid tready tdata tuser       command: operation, amount, date
//  m_axis    out  tvalid tready tdata             date after the command, status
//
//  Set, compare and year commands pass the queue, post state and output register;
//  day and month commands also pass the step state, one step of the date per cycle.
//  The stepping sequencer in the back part makes as many steps as the amount.
//  Synchronous active-low reset returns the date to 1 January 1600; no sweep follows.
//  Two commands queue ahead of the sequencer; a stalled result is held in the
//  output register while the next command is worked on.
module calendar_date_stepper_core #(
    parameter int unsigned AMOUNT_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // amount, day_in, month_in, year_in from bit 0 up, zero padded to bytes
    input  logic [((AMOUNT_WIDTH+cds_pkg::DATE_W+7)/8)*8-1:0] i_s_axis_tdata,
    // operation
    input  logic [2:0] i_s_axis_tuser,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // day_out, month_out, year_out, month_length, leap, matches_res from bit 0 up
    output logic [cds_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import cds_pkg::*;

    localparam int unsigned ENT_W = $bits(t_cls) + AMOUNT_WIDTH + DATE_W;

    logic             w_full;
    logic             w_push;
    logic             w_pop;
    logic             w_q_valid;
    logic [ENT_W-1:0] w_entry_in;
    logic [ENT_W-1:0] w_entry_out;
    t_result          w_result;

    // Decode and accept commands
    cds_front #(
        .AMOUNT_WIDTH(AMOUNT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_operation (i_s_axis_tuser),
        .i_amount    (i_s_axis_tdata[AMOUNT_WIDTH-1:0]),
        .i_day       (i_s_axis_tdata[AMOUNT_WIDTH+4:AMOUNT_WIDTH]),
        .i_month     (i_s_axis_tdata[AMOUNT_WIDTH+8:AMOUNT_WIDTH+5]),
        .i_year      (i_s_axis_tdata[AMOUNT_WIDTH+20:AMOUNT_WIDTH+9]),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_entry     (w_entry_in)
    );

    // Buffer decoded commands
    cds_queue #(
        .DATA_W(ENT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_entry_in),
        .i_pop   (w_pop),
        .o_data  (w_entry_out),
        .o_full  (w_full),
        .o_valid (w_q_valid)
    );

    // Carry out commands on the stored date
    cds_back #(
        .AMOUNT_WIDTH(AMOUNT_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_valid (w_q_valid),
        .i_entry       (w_entry_out),
        .o_pop         (w_pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_result      (w_result)
    );

    assign o_m_axis_tdata = OUT_DATA_W'(w_result);

endmodule

FILE: src/cds_front.sv
// Front part: input handshake and decode of the operation into a work class.
module cds_front #(
    parameter int unsigned AMOUNT_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [2:0]              i_operation,
    input  logic [AMOUNT_WIDTH-1:0] i_amount,
    input  logic [4:0]              i_day,
    input  logic [3:0]              i_month,
    input  logic [11:0]             i_year,
    input  logic                    i_full,
    output logic                    o_push,
    output logic [$bits(cds_pkg::t_cls)+AMOUNT_WIDTH+cds_pkg::DATE_W-1:0] o_entry
);
    import cds_pkg::*;

    t_cls w_cls;
    logic r_seen;

    // Map each operation onto a class and a direction
    always_comb begin
        w_cls.down = 1'b0;
        case (t_op'(i_operation))
            OP_SET:       w_cls.kind = K_SET;
            OP_ADD_DAYS:  w_cls.kind = K_DAY;
            OP_SUB_DAYS: begin
                w_cls.kind = K_DAY;
                w_cls.down = 1'b1;
            end
            OP_ADD_MONTH: w_cls.kind = K_MONTH;
            OP_SUB_MONTH: begin
                w_cls.kind = K_MONTH;
                w_cls.down = 1'b1;
            end
            OP_ADD_YEARS: w_cls.kind = K_YEAR;
            OP_SUB_YEARS: begin
                w_cls.kind = K_YEAR;
                w_cls.down = 1'b1;
            end
            default:      w_cls.kind = K_CMP;
        endcase
    end

    // Accept a transfer whenever the queue has room, once reset has been released
    assign o_ready = !i_full && r_seen;
    assign o_push  = i_valid && o_ready;
    assign o_entry = {w_cls, i_amount, i_day, i_month, i_year};

    // Hold off input during reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= 1'b1;
        end
    end

endmodule

FILE: src/cds_queue.sv
// Two-entry queue between the front and back parts.
module cds_queue #(
    parameter int unsigned DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_valid
);
    import cds_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: src/cds_back.sv
// Back part: holds the date, steps it one day or month per cycle, registers results.
module cds_back #(
    parameter int unsigned AMOUNT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_entry_valid,
    input  logic [$bits(cds_pkg::t_cls)+AMOUNT_WIDTH+cds_pkg::DATE_W-1:0] i_entry,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output cds_pkg::t_result      o_result
);
    import cds_pkg::*;

    localparam int unsigned SUM_W = ((AMOUNT_WIDTH > 12) ? AMOUNT_WIDTH : 12) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_POST
    } t_state;

    t_state                  r_state, n_state;
    logic [4:0]              r_day, n_day;
    logic [3:0]              r_month, n_month;
    logic [11:0]             r_year, n_year;
    logic [AMOUNT_WIDTH-1:0] r_cnt, n_cnt;
    t_kind                   r_kind, n_kind;
    logic                    r_down, n_down;
    logic                    r_match, n_match;
    logic                    r_out_valid, n_out_valid;
    t_result                 r_out, n_out;

    t_cls                    e_cls;
    logic [AMOUNT_WIDTH-1:0] e_amount;
    logic [4:0]              e_day;
    logic [3:0]              e_month;
    logic [11:0]             e_year;

    logic [3:0]              w_mu_month, w_md_month;
    logic [11:0]             w_mu_year, w_md_year;
    logic [4:0]              w_cur_len, w_md_len, w_set_len;
    logic [SUM_W-1:0]        w_sum, w_diff;
    logic [11:0]             w_set_year;
    logic [3:0]              w_set_month;

    assign {e_cls, e_amount, e_day, e_month, e_year} = i_entry;

    // Month carry and borrow, year held at the range ends
    always_comb begin
        if (r_month < MONTH_MAX) begin
            w_mu_month = r_month + 4'd1;
            w_mu_year  = r_year;
        end else begin
            w_mu_month = 4'd1;
            w_mu_year  = (r_year < YEAR_MAX) ? r_year + 12'd1 : r_year;
        end
        if (r_month > 4'd1) begin
            w_md_month = r_month - 4'd1;
            w_md_year  = r_year;
        end else begin
            w_md_month = MONTH_MAX;
            w_md_year  = (r_year > YEAR_MIN) ? r_year - 12'd1 : r_year;
        end
    end

    assign w_cur_len   = cds_month_len(r_month, cds_is_leap(r_year));
    assign w_md_len    = cds_month_len(w_md_month, cds_is_leap(w_md_year));
    assign w_sum       = SUM_W'(r_year) + SUM_W'(e_amount);
    assign w_diff      = SUM_W'(r_year) - SUM_W'(e_amount);
    assign w_set_year  = (e_year >= YEAR_MIN && e_year <= YEAR_MAX) ? e_year : YEAR_MIN;
    assign w_set_month = (e_month >= 4'd1 && e_month <= MONTH_MAX) ? e_month : 4'd1;
    assign w_set_len   = cds_month_len(w_set_month, cds_is_leap(w_set_year));

    // Next-state logic for the sequencer
    always_comb begin
        n_state     = r_state;
        n_day       = r_day;
        n_month     = r_month;
        n_year      = r_year;
        n_cnt       = r_cnt;
        n_kind      = r_kind;
        n_down      = r_down;
        n_match     = r_match;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_entry_valid) begin
                    o_pop   = 1'b1;
                    n_kind  = e_cls.kind;
                    n_down  = e_cls.down;
                    n_cnt   = e_amount;
                    n_match = 1'b0;
                    n_state = S_POST;
                    case (e_cls.kind)
                        K_SET: begin
                            n_year  = w_set_year;
                            n_month = w_set_month;
                            n_day   = (e_day >= 5'd1 && e_day <= w_set_len) ? e_day : 5'd1;
                        end
                        K_YEAR: begin
                            if (!e_cls.down && w_sum <= SUM_W'(YEAR_MAX)) begin
                                n_year = w_sum[11:0];
                            end
                            if (e_cls.down && SUM_W'(e_amount) <= SUM_W'(r_year - YEAR_MIN)) begin
                                n_year = w_diff[11:0];
                            end
                        end
                        K_DAY, K_MONTH: n_state = S_STEP;
                        default: begin
                            n_match = (r_day == e_day) && (r_month == e_month) &&
                                      (r_year == e_year);
                        end
                    endcase
                end
            end
            S_STEP: begin
                if (r_cnt == '0) begin
                    n_state = S_POST;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                    if (r_kind == K_MONTH) begin
                        n_month = r_down ? w_md_month : w_mu_month;
                        n_year  = r_down ? w_md_year  : w_mu_year;
                    end else if (!r_down) begin
                        if (r_day < w_cur_len) begin
                            n_day = r_day + 5'd1;
                        end else begin
                            n_day   = 5'd1;
                            n_month = w_mu_month;
                            n_year  = w_mu_year;
                        end
                    end else begin
                        if (r_day > 5'd1) begin
                            n_day = r_day - 5'd1;
                        end else begin
                            n_day   = w_md_len;
                            n_month = w_md_month;
                            n_year  = w_md_year;
                        end
                    end
                end
            end
            S_POST: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid        = 1'b1;
                    n_out.day_out      = r_day;
                    n_out.month_out    = r_month;
                    n_out.year_out     = r_year;
                    n_out.month_length = w_cur_len;
                    n_out.leap         = cds_is_leap(r_year);
                    n_out.matches_res  = r_match;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state, date and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_day       <= 5'd1;
            r_month     <= 4'd1;
            r_year      <= YEAR_MIN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_day       <= n_day;
            r_month     <= n_month;
            r_year      <= n_year;
            r_out_valid <= n_out_valid;
        end
        r_cnt   <= n_cnt;
        r_kind  <= n_kind;
        r_down  <= n_down;
        r_match <= n_match;
        r_out   <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_month >= 4'd1 && r_month <= MONTH_MAX)
        else $error("month left 1..12");

    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_year >= YEAR_MIN && r_year <= YEAR_MAX)
        else $error("year left the kept range");

    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_day >= 5'd1)
        else $error("day reached zero");

    a_post_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POST && r_out_valid && !i_ready |=> r_state == S_POST)
        else $error("result posted over a waiting one");

endmodule
